@@ rtl/core/utf8vc_pkg.sv @@
// ============================================================================
// UTF-8 validator package
// Shared character classes, byte constants, result records and the lead
// byte decode used by the front end of the validator.
// ============================================================================
package utf8vc_pkg;

  // Default number of result records held between front and back.
  localparam int QueueDepthDefault = 4;

  typedef enum logic [2:0] {
    CLS_ASCII         = 3'd0,
    CLS_CONTENT       = 3'd1,
    CLS_NOT_PRINTABLE = 3'd2,
    CLS_NEXT_LINE     = 3'd3,
    CLS_ZWNBSP        = 3'd4,
    CLS_INVALID       = 3'd5
  } char_class_t;

  localparam logic [7:0] AsciiLimit    = 8'h80;
  localparam logic [7:0] ContMask      = 8'hC0;
  localparam logic [7:0] ContMin       = 8'h80;
  localparam logic [7:0] ContMax       = 8'hBF;
  localparam logic [7:0] LeadTwoMin    = 8'hC2;
  localparam logic [7:0] LeadTwoMax    = 8'hDF;
  localparam logic [7:0] LeadE0        = 8'hE0;
  localparam logic [7:0] SecondE0Min   = 8'hA0;
  localparam logic [7:0] LeadED        = 8'hED;
  localparam logic [7:0] SecondEDMax   = 8'h9F;
  localparam logic [7:0] LeadThreeMax  = 8'hEF;
  localparam logic [7:0] LeadF0        = 8'hF0;
  localparam logic [7:0] SecondF0Min   = 8'h90;
  localparam logic [7:0] LeadF4        = 8'hF4;
  localparam logic [7:0] SecondF4Max   = 8'h8F;
  localparam logic [7:0] NextLineByte  = 8'h85;
  localparam logic [7:0] ZwnbspSecond  = 8'hBB;
  localparam logic [7:0] C1Limit       = 8'hA0;
  localparam logic [7:0] NonCharThird  = 8'hBE;

  localparam logic [2:0] LenNone  = 3'd0;
  localparam logic [2:0] LenOne   = 3'd1;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  typedef struct packed {
    logic [2:0] len;
    logic [7:0] lo;
    logic [7:0] hi;
  } shape_t;

  typedef struct packed {
    char_class_t cls;
    logic [2:0]  cnt;
  } result_t;

  // One accepted byte yields at most two results; they travel together.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  // Sequence length opened by a lead byte and the legal second-byte range.
  function automatic shape_t shape_of(input logic [7:0] b);
    shape_t s;
    s.len = LenNone;
    s.lo  = ContMin;
    s.hi  = ContMax;
    case (b) inside
      [LeadTwoMin:LeadTwoMax]: s.len = LenTwo;
      LeadE0: begin
        s.len = LenThree;
        s.lo  = SecondE0Min;
      end
      LeadED: begin
        s.len = LenThree;
        s.hi  = SecondEDMax;
      end
      [LeadE0:LeadThreeMax]: s.len = LenThree;
      LeadF0: begin
        s.len = LenFour;
        s.lo  = SecondF0Min;
      end
      LeadF4: begin
        s.len = LenFour;
        s.hi  = SecondF4Max;
      end
      [LeadF0:LeadF4]: s.len = LenFour;
      default: s.len = LenNone;
    endcase
    return s;
  endfunction

  // Class of a completed multi-byte character.
  function automatic char_class_t classify(input logic [7:0] lead,
                                           input logic [7:0] second,
                                           input logic [7:0] third,
                                           input logic [2:0] len);
    char_class_t c;
    c = CLS_CONTENT;
    if (len == LenTwo && lead == LeadTwoMin) begin
      if (second == NextLineByte) begin
        c = CLS_NEXT_LINE;
      end else if (second < C1Limit) begin
        c = CLS_NOT_PRINTABLE;
      end
    end else if (len == LenThree && lead == LeadThreeMax) begin
      if (second == ZwnbspSecond && third == ContMax) begin
        c = CLS_ZWNBSP;
      end else if (second == ContMax && third >= NonCharThird) begin
        c = CLS_NOT_PRINTABLE;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/utf8vc_front.sv @@
// ============================================================================
// UTF-8 validator front end
// Takes one byte per beat while full is low, tracks the open sequence and forms
// the one or two results that the byte causes as a single record for the queue.
// ============================================================================
module utf8vc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_input,
  output logic                  wr_en,
  output utf8vc_pkg::entry_t    wr_entry
);
  import utf8vc_pkg::*;

  logic [7:0] held_lead;
  logic [7:0] held_lead_next;
  logic [2:0] expected_length;
  logic [2:0] expected_length_next;
  logic [1:0] bytes_held;
  logic [1:0] bytes_held_next;
  logic [7:0] held_second;
  logic [7:0] held_second_next;

  logic       accept;
  shape_t     cur_shape;
  shape_t     new_shape;
  logic       start_emit;
  result_t    start_res;
  logic       ok;
  logic [2:0] held_cnt;
  logic [7:0] second;
  logic       has_result;

  assign accept    = push && !full;
  assign cur_shape = shape_of(held_lead);
  assign new_shape = shape_of(data_byte);
  assign held_cnt  = {1'b0, bytes_held} + 3'd1;
  assign second    = (bytes_held == 2'd1) ? data_byte : held_second;

  // Byte seen as the start of a new character.
  always_comb begin
    start_emit = 1'b1;
    start_res  = '{cls: CLS_INVALID, cnt: LenOne};
    if (data_byte < AsciiLimit) begin
      start_res.cls = CLS_ASCII;
    end else if (new_shape.len != LenNone && !end_of_input) begin
      start_emit = 1'b0;
    end
  end

  always_comb begin
    ok = (bytes_held == 2'd1) ? (data_byte >= cur_shape.lo && data_byte <= cur_shape.hi)
                              : ((data_byte & ContMask) == ContMin);
  end

  always_comb begin
    held_lead_next       = held_lead;
    expected_length_next = expected_length;
    bytes_held_next      = bytes_held;
    held_second_next     = held_second;
    has_result           = 1'b0;
    wr_entry             = '{two: 1'b0, r0: start_res, r1: start_res};
    if (expected_length == LenNone || !ok) begin
      // Close whatever was open, then treat the byte as a new start.
      held_lead_next       = '0;
      expected_length_next = LenNone;
      bytes_held_next      = '0;
      held_second_next     = '0;
      if (!start_emit) begin
        held_lead_next       = data_byte;
        expected_length_next = new_shape.len;
        bytes_held_next      = 2'd1;
      end
      if (expected_length == LenNone) begin
        has_result = start_emit;
      end else begin
        has_result   = 1'b1;
        wr_entry.r0  = '{cls: CLS_INVALID, cnt: {1'b0, bytes_held}};
        wr_entry.two = start_emit;
      end
    end else if (held_cnt >= expected_length) begin
      has_result  = 1'b1;
      wr_entry.r0 = '{cls: classify(held_lead, second, data_byte, expected_length),
                      cnt: expected_length};
      held_lead_next       = '0;
      expected_length_next = LenNone;
      bytes_held_next      = '0;
      held_second_next     = '0;
    end else begin
      if (bytes_held == 2'd1) begin
        held_second_next = data_byte;
      end
      bytes_held_next = held_cnt[1:0];
      if (end_of_input) begin
        has_result  = 1'b1;
        wr_entry.r0 = '{cls: CLS_INVALID, cnt: held_cnt};
        held_lead_next       = '0;
        expected_length_next = LenNone;
        bytes_held_next      = '0;
        held_second_next     = '0;
      end
    end
  end

  assign wr_en = accept && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead       <= '0;
      expected_length <= LenNone;
      bytes_held      <= '0;
      held_second     <= '0;
    end else if (accept) begin
      held_lead       <= held_lead_next;
      expected_length <= expected_length_next;
      bytes_held      <= bytes_held_next;
      held_second     <= held_second_next;
    end
  end

  // An open sequence always holds at least one byte and fewer than its length.
  a_open_consistent: assert property (@(posedge clk) disable iff (rst)
    expected_length != LenNone |-> bytes_held != 2'd0 && {1'b0, bytes_held} < expected_length)
    else $error("open sequence inconsistent");

  // A byte taken with no sequence open never yields two results.
  a_two_needs_open: assert property (@(posedge clk) disable iff (rst)
    wr_en && expected_length == LenNone |-> !wr_entry.two)
    else $error("two results from a fresh start");

endmodule

@@ rtl/core/utf8vc_queue.sv @@
// ============================================================================
// UTF-8 validator result queue
// Small first-in first-out store of result records between front and back.
// ============================================================================
module utf8vc_queue #(
  parameter int Depth = utf8vc_pkg::QueueDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  utf8vc_pkg::entry_t wr_entry,
  input  logic               rd_en,
  output utf8vc_pkg::entry_t rd_entry,
  output logic               full,
  output logic               empty
);
  import utf8vc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  entry_t          store [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == DepthCnt);
  assign empty    = (count == '0);
  assign rd_entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(wr_en) - CntW'(rd_en);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd_en |-> !empty)
    else $error("read from empty queue");

endmodule

@@ rtl/core/utf8vc_back.sv @@
// ============================================================================
// UTF-8 validator back end
// Hands the results of the head record out one beat at a time and retires
// the record after its last result is taken.
// ============================================================================
module utf8vc_back (
  input  logic               clk,
  input  logic               rst,
  input  utf8vc_pkg::entry_t rd_entry,
  input  logic               empty,
  input  logic               pop,
  output logic               rd_en,
  output logic [2:0]         char_class,
  output logic [2:0]         byte_count,
  output logic               run_last
);
  import utf8vc_pkg::*;

  logic    sel;
  result_t cur;
  logic    take;

  assign cur        = sel ? rd_entry.r1 : rd_entry.r0;
  assign char_class = cur.cls;
  assign byte_count = cur.cnt;
  assign run_last   = !rd_entry.two || sel;
  assign take       = pop && !empty;
  assign rd_en      = take && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (take) begin
      sel <= !run_last;
    end
  end

  // The second result of a record is only ever shown for a two-result record.
  a_sel_two: assert property (@(posedge clk) disable iff (rst)
    sel && !empty |-> rd_entry.two)
    else $error("second result selected on single record");

endmodule

@@ rtl/core/utf8_validate_classify.sv @@
// ============================================================================
// UTF-8 validator and character classifier
// Validates a byte stream against RFC 3629 and reports each character's
// class and length, or invalid results for broken or truncated sequences.
// ============================================================================
// Latency: a result can be taken in the cycle after the byte that caused it.
// Throughput: one byte per cycle on the input while the queue is not full;
//   results leave at one per cycle while pop is held, one for each result.
// The output rate is set by the back end, which shows one result at a time.
// Reset (synchronous, rst high) closes any open sequence and empties the
//   queue; no clearing pass is needed.
module utf8_validate_classify #(
  parameter int QueueDepth = utf8vc_pkg::QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] char_class,
  output logic [2:0] byte_count,
  output logic       run_last
);
  import utf8vc_pkg::*;

  // Each input beat is classified in the front end in the cycle it is
  // accepted. Any results it causes (at most two: the invalid report for a
  // broken sequence, followed by the restart of the same byte) are packed
  // into one record and written to the queue at that same edge.
  logic   wr_en;
  entry_t wr_entry;
  logic   rd_en;
  entry_t rd_entry;

  utf8vc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .end_of_input (end_of_input),
    .wr_en        (wr_en),
    .wr_entry     (wr_entry)
  );

  // The queue decouples the two sides: the front keeps taking bytes while
  // earlier results wait for the consumer, and stalls only when full.
  utf8vc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_entry (rd_entry),
    .full     (full),
    .empty    (empty)
  );

  // The back end presents the head record one result beat at a time and
  // marks the last result of each byte with run_last.
  utf8vc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_entry   (rd_entry),
    .empty      (empty),
    .pop        (pop),
    .rd_en      (rd_en),
    .char_class (char_class),
    .byte_count (byte_count),
    .run_last   (run_last)
  );

  // After a byte that yields a result is written, the queue is not empty in the next cycle.
  a_result_visible: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> !empty)
    else $error("queued result not visible");

  // Every result beat carries a length of one to four bytes.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> byte_count != 3'd0 && byte_count <= LenFour)
    else $error("byte count out of range");

endmodule
